/* design/dest_pkg.sv */
// Package with shared types, constants and codes of the diagnostic event status tracker.
`timescale 1ns / 1ps

package dest_pkg;

  // Table geometry: four code registers exist, the first NUM_ENTRIES of them are scanned.
  localparam int TABLE_SLOTS = 4;
  localparam int NUM_ENTRIES = 4;
  localparam int IDX_W       = $clog2(TABLE_SLOTS);
  localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(NUM_ENTRIES - 1);

  // Field widths.
  localparam int CODE_W    = 24;
  localparam int CNT_W     = 16;
  localparam int THR_W     = 8;
  localparam int MASK_W    = TABLE_SLOTS;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = CODE_W;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  // Reset values of the thresholds.
  localparam logic [THR_W-1:0] CONFIRM_THR_RESET = THR_W'(3);
  localparam logic [THR_W-1:0] AGING_THR_RESET   = THR_W'(40);

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_CODE_A      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_B      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_C      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_D      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_THR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AGING_THR   = 3'd6;

  // Item opcodes.
  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Status of one trouble code.
  typedef enum logic [STATUS_W-1:0] {
    ST_PASSED    = 2'd0,
    ST_FAILED    = 2'd1,
    ST_PENDING   = 2'd2,
    ST_CONFIRMED = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_CLEAR,
    S_DONE
  } state_t;

  // Operands of the shared compare and count unit.
  typedef struct packed {
    logic [CODE_W-1:0] code_a;
    logic [CODE_W-1:0] code_b;
    logic [CNT_W-1:0]  cnt;
    logic [THR_W-1:0]  thr;
  } alu_req_t;

  // Results of the shared compare and count unit.
  typedef struct packed {
    logic             eq;
    logic [CNT_W-1:0] inc;
    logic             reached;
  } alu_rsp_t;

endpackage

/* design/dest_alu.sv */
// Shared compare and saturating count unit used by the tracker sequencer.
`timescale 1ns / 1ps

module dest_alu (
  input  dest_pkg::alu_req_t req,
  output dest_pkg::alu_rsp_t rsp
);
  import dest_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  logic [CNT_W-1:0] inc;

  // Code compare for the scan step.
  assign rsp.eq = (req.code_a == req.code_b);

  // Saturating increment and threshold check for the update step.
  assign inc         = (req.cnt == CNT_MAX) ? CNT_MAX : req.cnt + CNT_W'(1);
  assign rsp.inc     = inc;
  assign rsp.reached = (inc >= {{(CNT_W-THR_W){1'b0}}, req.thr});

endmodule

/* design/diagnostic_event_status_tracker_top.sv */
// Top level of the diagnostic event status tracker: sequencer, tables and stream ports.
`timescale 1ns / 1ps
//
// Usage:
//   Items arrive on the s_* stream. s_tuser is the opcode (report or clear all),
//   s_tdata carries the trouble code and the pass or fail result. Each item gives
//   exactly one result transaction on the m_* stream.
//   The cfg_* channel writes the four entry codes, the enable mask and the two
//   thresholds; it is always ready. It must be written only while the block is
//   idle; the block itself does not enforce this. One shared compare unit
//   walks the table one entry per cycle. A report is accepted, scans the entries
//   in order until the first enabled match or the last entry, takes an update
//   step when it matches and then hands over the result. A clear item sweeps
//   all entries before its hand-over. s_tready is high only between items.
//   The result sits in an output register; a stalled receiver holds the next item
//   in its hand-over step until the register is free.
//   Synchronous reset clears the sequencer, all table entries (passed, zero
//   counters) and returns the registers to their reset values.
//
module diagnostic_event_status_tracker_top (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata fields from bit 0: report_code[23:0], failed_flag[24], zero padding.
  input  logic [dest_pkg::IN_DATA_W-1:0]      s_tdata,
  // s_tuser fields from bit 0: opcode[0].
  input  logic                                s_tuser,
  // Result stream.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata fields from bit 0: matched[0], entry_status[2:1], occurrences[18:3],
  // aging_count[34:19], zero padding.
  output logic [dest_pkg::OUT_DATA_W-1:0]     m_tdata,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dest_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dest_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dest_pkg::*;

  // Configuration registers.
  logic [CODE_W-1:0] event_codes [TABLE_SLOTS];
  logic [MASK_W-1:0] enable_mask;
  logic [THR_W-1:0]  confirm_thr;
  logic [THR_W-1:0]  aging_thr;

  // Entry tables.
  status_t          status_table [TABLE_SLOTS];
  logic [CNT_W-1:0] occ_table    [TABLE_SLOTS];
  logic [CNT_W-1:0] aging_table  [TABLE_SLOTS];

  // Sequencer and item registers.
  state_t           state, state_next;
  logic [IDX_W-1:0] idx;
  logic [CODE_W-1:0] code_q;
  logic             failed_q;

  // Staged result and output register.
  logic             res_matched;
  status_t          res_status;
  logic [CNT_W-1:0] res_occ;
  logic [CNT_W-1:0] res_aging;
  logic             out_valid;
  logic             out_matched;
  logic [STATUS_W-1:0] out_status;
  logic [CNT_W-1:0] out_occ;
  logic [CNT_W-1:0] out_aging;

  // Control strobes and shared unit wiring.
  logic     accept;
  logic     hit;
  logic     load_out;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  // Update values of the selected entry.
  status_t          upd_status;
  logic [CNT_W-1:0] upd_occ;
  logic [CNT_W-1:0] upd_aging;

  dest_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign hit       = enable_mask[idx] && alu_rsp.eq;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        event_codes[i] <= '0;
      end
      enable_mask <= '0;
      confirm_thr <= CONFIRM_THR_RESET;
      aging_thr   <= AGING_THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CODE_A:      event_codes[0] <= cfg_data[CODE_W-1:0];
        REG_CODE_B:      event_codes[1] <= cfg_data[CODE_W-1:0];
        REG_CODE_C:      event_codes[2] <= cfg_data[CODE_W-1:0];
        REG_CODE_D:      event_codes[3] <= cfg_data[CODE_W-1:0];
        REG_ENABLE_MASK: enable_mask    <= cfg_data[MASK_W-1:0];
        REG_CONFIRM_THR: confirm_thr    <= cfg_data[THR_W-1:0];
        REG_AGING_THR:   aging_thr      <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tuser == OP_CLEAR) ? S_CLEAR : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_next = S_UPDATE;
        end else if (idx == LAST_ENTRY) begin
          state_next = S_DONE;
        end
      end
      S_UPDATE: state_next = S_DONE;
      S_CLEAR: begin
        if (idx == LAST_ENTRY) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs and operand selection for the shared unit.
  always_comb begin
    s_tready       = (state == S_IDLE);
    load_out       = (state == S_DONE) && (!out_valid || m_tready);
    alu_req.code_a = code_q;
    alu_req.code_b = event_codes[idx];
    alu_req.cnt    = failed_q ? occ_table[idx] : aging_table[idx];
    alu_req.thr    = failed_q ? confirm_thr : aging_thr;
  end

  // New status and counters of the matched entry.
  always_comb begin
    if (failed_q) begin
      upd_occ    = alu_rsp.inc;
      upd_aging  = '0;
      upd_status = alu_rsp.reached ? ST_CONFIRMED : ST_FAILED;
    end else begin
      upd_occ   = occ_table[idx];
      upd_aging = alu_rsp.inc;
      if (alu_rsp.reached) begin
        upd_status = ST_PASSED;
      end else if (status_table[idx] == ST_FAILED) begin
        upd_status = ST_PENDING;
      end else begin
        upd_status = status_table[idx];
      end
    end
  end

  // Sequencer state, entry index and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        idx <= '0;
      end else if ((state == S_SCAN && !hit) || state == S_CLEAR) begin
        if (idx != LAST_ENTRY) begin
          idx <= idx + IDX_W'(1);
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Entry tables: update on a match, swept to passed and zero by a clear item.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        status_table[i] <= ST_PASSED;
        occ_table[i]    <= '0;
        aging_table[i]  <= '0;
      end
    end else if (state == S_UPDATE) begin
      status_table[idx] <= upd_status;
      occ_table[idx]    <= upd_occ;
      aging_table[idx]  <= upd_aging;
    end else if (state == S_CLEAR) begin
      status_table[idx] <= ST_PASSED;
      occ_table[idx]    <= '0;
      aging_table[idx]  <= '0;
    end
  end

  // Item payload, staged result and output register.
  always_ff @(posedge clk) begin
    if (accept) begin
      code_q      <= s_tdata[CODE_W-1:0];
      failed_q    <= s_tdata[CODE_W];
      res_matched <= 1'b0;
      res_status  <= ST_PASSED;
      res_occ     <= '0;
      res_aging   <= '0;
    end else if (state == S_UPDATE) begin
      res_matched <= 1'b1;
      res_status  <= upd_status;
      res_occ     <= upd_occ;
      res_aging   <= upd_aging;
    end
    if (load_out) begin
      out_matched <= res_matched;
      out_status  <= res_status;
      out_occ     <= res_occ;
      out_aging   <= res_aging;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W-1-STATUS_W-2*CNT_W){1'b0}},
                     out_aging, out_occ, out_status, out_matched};

`ifndef NO_ASSERTIONS
  // An accepted item keeps the input closed until its result is handed over.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input ready again right after an accepted item");

  // The scan and clear index stays within the table.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_CLEAR || state == S_UPDATE) |-> (idx <= LAST_ENTRY))
    else $error("entry index beyond the last table entry");

  // A result without a match carries all zero fields.
  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[OUT_DATA_W-1:1] == '0))
    else $error("unmatched result with nonzero fields");

  // A confirmed entry has seen at least one failure.
  a_confirmed_occ: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:1] == ST_CONFIRMED) |-> (m_tdata[18:3] != '0))
    else $error("confirmed result with zero occurrences");

  // A new result only comes from the hand-over state.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_DONE))
    else $error("result appeared outside the hand-over step");
`endif

endmodule

/* tb/sv/tb_diagnostic_event_status_tracker_top.sv */
// Self-checking testbench for the diagnostic event status tracker top level.
`timescale 1ns / 1ps

module tb_diagnostic_event_status_tracker_top;
  import dest_pkg::*;

  localparam int unsigned CYCLE_LIMIT       = 200000;
  localparam int unsigned LONG_HOLD_CYCLES  = 80;
  localparam int unsigned RANDOM_PHASES     = 8;
  localparam int unsigned ITEMS_PER_PHASE   = 45;
  localparam int unsigned SINGLE_ENTRY_RUN  = 8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic [CODE_W-1:0] CODE_ZERO = 24'h000000;
  localparam logic [CODE_W-1:0] CODE_HIGH = 24'hFFFFFF;
  localparam logic [CODE_W-1:0] CODE_MID  = 24'h5A5A5A;

  // One result transaction as it is packed on m_tdata.
  typedef struct packed {
    logic [CNT_W-1:0]    aging;
    logic [CNT_W-1:0]    occurrences;
    logic [STATUS_W-1:0] status;
    logic                matched;
  } status_report_t;

  // Mirror of the trouble code table: predicts each status report and checks the DUT.
  class trouble_code_ledger;
    logic [CODE_W-1:0] entry_code [TABLE_SLOTS];
    logic [MASK_W-1:0] enable_mask;
    logic [THR_W-1:0]  confirm_thr;
    logic [THR_W-1:0]  aging_thr;
    status_t           status_tbl [TABLE_SLOTS];
    logic [CNT_W-1:0]  occ_tbl    [TABLE_SLOTS];
    logic [CNT_W-1:0]  age_tbl    [TABLE_SLOTS];
    status_report_t    expected_status_reports [$];
    int                errors;

    function new();
      errors = 0;
      for (int i = 0; i < TABLE_SLOTS; i++) entry_code[i] = '0;
      enable_mask = '0;
      confirm_thr = CONFIRM_THR_RESET;
      aging_thr   = AGING_THR_RESET;
      clear_entries();
    endfunction

    function void clear_entries();
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        status_tbl[i] = ST_PASSED;
        occ_tbl[i]    = '0;
        age_tbl[i]    = '0;
      end
    endfunction

    function logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    // Register write as seen by the table; unknown indexes are dropped.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CODE_A, REG_CODE_B, REG_CODE_C, REG_CODE_D: begin
          entry_code[IDX_W'(idx - REG_CODE_A)] = data[CODE_W-1:0];
        end
        REG_ENABLE_MASK: enable_mask = data[MASK_W-1:0];
        REG_CONFIRM_THR: confirm_thr = data[THR_W-1:0];
        REG_AGING_THR:   aging_thr   = data[THR_W-1:0];
        default: ;
      endcase
    endfunction

    // Accepted input item: update the mirror table and queue the expected report.
    function void note_report(logic op, logic [CODE_W-1:0] code, logic failed);
      status_report_t rep;
      bit             hit;
      rep = '0;
      hit = 1'b0;
      if (op == OP_CLEAR) begin
        clear_entries();
      end else begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (!hit && enable_mask[i] && entry_code[i] == code) begin
            hit = 1'b1;
            if (failed) begin
              status_tbl[i] = ST_FAILED;
              occ_tbl[i]    = sat_inc(occ_tbl[i]);
              age_tbl[i]    = '0;
              if (occ_tbl[i] >= {8'b0, confirm_thr}) status_tbl[i] = ST_CONFIRMED;
            end else begin
              if (status_tbl[i] == ST_FAILED) status_tbl[i] = ST_PENDING;
              age_tbl[i] = sat_inc(age_tbl[i]);
              if (age_tbl[i] >= {8'b0, aging_thr}) status_tbl[i] = ST_PASSED;
            end
            rep.matched     = 1'b1;
            rep.status      = status_tbl[i];
            rep.occurrences = occ_tbl[i];
            rep.aging       = age_tbl[i];
          end
        end
      end
      expected_status_reports = {expected_status_reports, rep};
    endfunction

    // Accepted result transaction: compare it field by field with the oldest expectation.
    function void check_status_result(logic [OUT_DATA_W-1:0] tdata);
      status_report_t exp_r;
      status_report_t act_r;
      if (expected_status_reports.size() == 0) begin
        $error("result transaction with no pending item: m_tdata=%h", tdata);
        errors++;
        return;
      end
      exp_r = expected_status_reports.pop_front();
      act_r = tdata[$bits(status_report_t)-1:0];
      if (act_r.matched !== exp_r.matched) begin
        $error("matched mismatch: expected %0d, actual %0d", exp_r.matched, act_r.matched);
        errors++;
      end
      if (act_r.status !== exp_r.status) begin
        $error("entry_status mismatch: expected %0d, actual %0d", exp_r.status, act_r.status);
        errors++;
      end
      if (act_r.occurrences !== exp_r.occurrences) begin
        $error("occurrences mismatch: expected %0d, actual %0d",
               exp_r.occurrences, act_r.occurrences);
        errors++;
      end
      if (act_r.aging !== exp_r.aging) begin
        $error("aging_count mismatch: expected %0d, actual %0d", exp_r.aging, act_r.aging);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  trouble_code_ledger tracker;
  int unsigned cycle_count = 0;
  int unsigned tx_max_gap  = 0;
  int unsigned rx_max_low  = 0;
  int unsigned burst_left  = 0;
  int unsigned rx_left     = 0;
  int unsigned hold_left   = 0;
  int unsigned hold_req    = 0;
  int unsigned hold_ack    = 0;

  diagnostic_event_status_tracker_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock generation.
  initial begin
    forever #1 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      tracker.check_status_result(m_tdata);
    end
  end

  // Receiver: alternating ready and stall runs, plus an occasional long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      m_tready = 1'b0;
      rx_left  = 0;
    end else begin
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else if (rx_left > 0) begin
        rx_left--;
      end else if (m_tready && rx_max_low > 0) begin
        m_tready = 1'b0;
        rx_left  = $urandom_range(0, rx_max_low - 1);
      end else begin
        m_tready = 1'b1;
        rx_left  = $urandom_range(0, 15);
      end
    end
  end

  // Offer one item and hold it until the transaction completes; returns at a falling edge.
  task automatic send_item(input logic op, input logic [CODE_W-1:0] code, input logic failed);
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = IN_DATA_W'({failed, code});
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    tracker.note_report(op, code, failed);
    @(negedge clk);
  endtask

  // Send with bursts of random length separated by random gaps.
  task automatic offer_item(input logic op, input logic [CODE_W-1:0] code, input logic failed);
    send_item(op, code, failed);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if (tx_max_gap > 0) begin
        s_tvalid = 1'b0;
        repeat ($urandom_range(1, tx_max_gap)) begin
          s_tdata = $urandom;
          s_tuser = 1'($urandom);
          @(negedge clk);
        end
      end
    end
  endtask

  // Stop sending and wait until every expected report has arrived.
  task automatic drain_results();
    s_tvalid = 1'b0;
    while (tracker.expected_status_reports.size() != 0) @(negedge clk);
  endtask

  // One register write transaction; cfg_valid stays high for the caller to drop.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    tracker.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Threshold with a bias toward small values and the extremes, zero included.
  function automatic logic [CFG_DATA_W-1:0] pick_threshold();
    int unsigned r;
    logic [THR_W-1:0] thr;
    r = $urandom_range(0, 9);
    case (r)
      0: thr = 8'd0;
      1: thr = 8'd1;
      2: thr = 8'd255;
      default: thr = THR_W'($urandom_range(1, 8));
    endcase
    return {16'($urandom), thr};
  endfunction

  // Random table setup: codes drawn from a small pool so duplicates occur.
  task automatic program_random_setup();
    logic [CODE_W-1:0]    pool [4];
    logic [CFG_IDX_W-1:0] code_regs [4];
    int unsigned r;
    code_regs = '{REG_CODE_A, REG_CODE_B, REG_CODE_C, REG_CODE_D};
    for (int i = 0; i < 4; i++) begin
      r = $urandom_range(0, 7);
      pool[i] = (r == 0) ? CODE_ZERO : (r == 1) ? CODE_HIGH : CODE_W'($urandom);
    end
    for (int i = 0; i < 4; i++) write_reg(code_regs[i], pool[$urandom_range(0, 3)]);
    r = $urandom_range(0, 7);
    write_reg(REG_ENABLE_MASK, {20'($urandom), (r == 0) ? 4'h0 : 4'($urandom_range(1, 15))});
    write_reg(REG_CONFIRM_THR, pick_threshold());
    write_reg(REG_AGING_THR, pick_threshold());
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_valid = 1'b0;
  endtask

  // Main sequence.
  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned r;
    int unsigned fail_pct;
    tracker = new();
    repeat (8) @(negedge clk);
    rst = 1'b0;
    tx_max_gap = 3;
    rx_max_low = 4;

    // Reset setup: nothing enabled, so a report never matches; then a clear.
    offer_item(OP_REPORT, CODE_ZERO, 1'b1);
    offer_item(OP_CLEAR, CODE_HIGH, 1'b1);
    drain_results();

    // Directed table: duplicate high codes on entries one and three, low thresholds.
    write_reg(REG_CODE_A, CODE_ZERO);
    write_reg(REG_CODE_B, CODE_HIGH);
    write_reg(REG_CODE_C, CODE_MID);
    write_reg(REG_CODE_D, CODE_HIGH);
    write_reg(REG_ENABLE_MASK, 24'hFFFFFF);
    write_reg(REG_CONFIRM_THR, 24'h000002);
    write_reg(REG_AGING_THR, 24'h000003);
    write_reg(REG_UNUSED, 24'hA5A5A5);
    cfg_valid = 1'b0;
    // Fail twice to confirm, then pass until aging returns the entry to passed.
    offer_item(OP_REPORT, CODE_HIGH, 1'b1);
    offer_item(OP_REPORT, CODE_HIGH, 1'b1);
    offer_item(OP_REPORT, CODE_HIGH, 1'b0);
    offer_item(OP_REPORT, CODE_HIGH, 1'b0);
    offer_item(OP_REPORT, CODE_HIGH, 1'b0);
    // Failed to pending, then a fail again confirms and clears aging.
    offer_item(OP_REPORT, CODE_ZERO, 1'b1);
    offer_item(OP_REPORT, CODE_ZERO, 1'b0);
    offer_item(OP_REPORT, CODE_ZERO, 1'b1);
    offer_item(OP_REPORT, CODE_MID, 1'b0);
    offer_item(OP_REPORT, 24'h123456, 1'b1);
    offer_item(OP_REPORT, CODE_MID, 1'b1);
    offer_item(OP_CLEAR, CODE_HIGH, 1'b1);
    offer_item(OP_REPORT, CODE_HIGH, 1'b0);
    offer_item(OP_REPORT, CODE_MID ^ 24'h000001, 1'b1);
    drain_results();

    // Entry one disabled: the duplicate code now lands on entry three.
    write_reg(REG_ENABLE_MASK, 24'h00000D);
    cfg_valid = 1'b0;
    offer_item(OP_REPORT, CODE_HIGH, 1'b1);
    offer_item(OP_REPORT, CODE_MID, 1'b1);
    drain_results();

    // Zero thresholds: every fail confirms and every pass returns to passed.
    write_reg(REG_CONFIRM_THR, 24'hABCD00);
    write_reg(REG_AGING_THR, 24'h123400);
    cfg_valid = 1'b0;
    offer_item(OP_REPORT, CODE_ZERO, 1'b1);
    offer_item(OP_REPORT, CODE_ZERO, 1'b0);
    drain_results();

    // Largest thresholds.
    write_reg(REG_CONFIRM_THR, 24'h0000FF);
    write_reg(REG_AGING_THR, 24'hFFFFFF);
    cfg_valid = 1'b0;
    offer_item(OP_REPORT, CODE_MID, 1'b1);
    offer_item(OP_REPORT, CODE_MID, 1'b0);
    drain_results();

    // Random phases with fresh setups and varied idling.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      program_random_setup();
      tx_max_gap = (phase % 3 == 0) ? 0 : $urandom_range(1, 8);
      rx_max_low = (phase % 4 == 1) ? 0 : $urandom_range(1, 12);
      fail_pct   = $urandom_range(20, 80);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Long receiver hold-off while items keep coming, and one full pause.
        if (phase == 2 && n == 10) hold_req++;
        if (phase == 4 && n == 25) drain_results();
        r = $urandom_range(0, 99);
        if (r < 6) begin
          offer_item(OP_CLEAR, CODE_W'($urandom), 1'($urandom));
        end else if (r < 18) begin
          offer_item(OP_REPORT, CODE_W'($urandom), 1'($urandom));
        end else begin
          offer_item(OP_REPORT, tracker.entry_code[$urandom_range(0, TABLE_SLOTS - 1)],
                     ($urandom_range(0, 99) < fail_pct));
        end
      end
    end

    // Single entry run: fails past the confirm threshold, then passes until it ages out.
    drain_results();
    write_reg(REG_CODE_A, CODE_W'($urandom));
    write_reg(REG_ENABLE_MASK, 24'h000001);
    write_reg(REG_CONFIRM_THR, 24'h000005);
    write_reg(REG_AGING_THR, 24'h000006);
    cfg_valid  = 1'b0;
    tx_max_gap = 0;
    rx_max_low = 0;
    offer_item(OP_CLEAR, CODE_ZERO, 1'b0);
    for (n = 0; n < SINGLE_ENTRY_RUN; n++) offer_item(OP_REPORT, tracker.entry_code[0], 1'b1);
    for (n = 0; n < SINGLE_ENTRY_RUN; n++) offer_item(OP_REPORT, tracker.entry_code[0], 1'b0);

    // Wind down and report.
    drain_results();
    repeat (NUM_ENTRIES + 8) @(negedge clk);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
